@@ hdl/bba_pkg.sv @@
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types, constants and helpers for the bitmap block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

    // Geometry of the used-block bitmap
    localparam int NUM_BLOCKS    = 1024;
    localparam int MAP_WORD_BITS = 32;
    localparam int MAP_WORDS     = (NUM_BLOCKS + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
    localparam int WORD_IDX_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int BIT_IDX_W     = $clog2(MAP_WORD_BITS);

    // Beat field widths
    localparam int CMD_W   = 2;
    localparam int BLK_W   = 10;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = $clog2(NUM_BLOCKS + 1);

    // Request codes
    localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

    // Status codes
    localparam logic [STAT_W-1:0] STAT_OK           = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL         = 2'd1;
    localparam logic [STAT_W-1:0] STAT_INVALID      = 2'd2;
    localparam logic [STAT_W-1:0] STAT_ALREADY_FREE = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [BLK_W-1:0] block_number;
    } t_req;

    typedef struct packed {
        logic [BLK_W-1:0]   block_out;
        logic               is_used;
        logic [STAT_W-1:0]  status;
        logic [COUNT_W-1:0] free_total;
    } t_resp;

    // Bitmap RAM access bundle
    typedef struct packed {
        logic                     rd_en;
        logic [WORD_IDX_W-1:0]    rd_addr;
        logic                     wr_en;
        logic [WORD_IDX_W-1:0]    wr_addr;
        logic [MAP_WORD_BITS-1:0] wr_data;
    } t_ram_req;

    typedef enum logic {
        ST_IDLE,
        ST_LOOK
    } t_state;

    // Index of the lowest set bit (0 when none is set)
    function automatic logic [BIT_IDX_W-1:0] lowest_set(input logic [MAP_WORD_BITS-1:0] v);
        logic [BIT_IDX_W-1:0] idx;
        idx = '0;
        for (int b = MAP_WORD_BITS - 1; b >= 0; b--) begin
            if (v[b]) begin
                idx = BIT_IDX_W'(b);
            end
        end
        return idx;
    endfunction

endpackage

@@ hdl/bba_map_ram.sv @@
// ----------------------------------------------------------------------------
// bba_map_ram
// Bitmap word store: one write and one registered read per cycle. A word
// never written since reset reads as all zero through its valid bit.
// ----------------------------------------------------------------------------
module bba_map_ram (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  bba_pkg::t_ram_req                 i_req,
    output logic [bba_pkg::MAP_WORD_BITS-1:0] o_rd_data
);

    logic [bba_pkg::MAP_WORD_BITS-1:0] r_mem [bba_pkg::MAP_WORDS];
    logic [bba_pkg::MAP_WORDS-1:0]     r_word_vld;
    logic [bba_pkg::MAP_WORD_BITS-1:0] r_rd_data;
    logic                              r_rd_vld;

    // Word storage
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    // Per-word valid bits, cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word_vld <= '0;
            r_rd_vld   <= 1'b0;
        end else begin
            if (i_req.wr_en) begin
                r_word_vld[i_req.wr_addr] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_rd_vld <= r_word_vld[i_req.rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

@@ hdl/bitmap_block_allocator.sv @@
// ----------------------------------------------------------------------------
// bitmap_block_allocator
// First-fit block allocator over a used-block bitmap held in a word RAM.
// ----------------------------------------------------------------------------
//
//  Channel   Signals                            Direction  Beat
//  request   i_in_valid / o_in_ready / i_in_data  in       t_req
//  result    o_out_valid / i_out_ready / o_out_data out    t_resp
//
//  Free and query read the bitmap word of their block once; allocate scans
//  1 to 32 bitmap words from word 0 upward, stopping at the first word with a
//  free block. The scan reads one word per cycle through the single RAM read port.
//  Reset clears the word valid bits at once; no clearing pass is needed.
//  One request is in flight at a time; a result stalled at the output holds
//  the request and its RAM write back until the beat is taken.
// ----------------------------------------------------------------------------
module bitmap_block_allocator (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  bba_pkg::t_req  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output bba_pkg::t_resp o_out_data
);

    bba_pkg::t_state                     r_state, n_state;
    bba_pkg::t_req                       r_req;
    logic [bba_pkg::WORD_IDX_W-1:0]      r_word, n_word;
    logic [bba_pkg::COUNT_W-1:0]         r_free_count, n_free_count;
    logic                                r_out_valid;
    bba_pkg::t_resp                      r_out_data;

    bba_pkg::t_ram_req                   ram_req;
    logic [bba_pkg::MAP_WORD_BITS-1:0]   rd_word;
    logic [bba_pkg::MAP_WORD_BITS-1:0]   alloc_mask;
    logic [bba_pkg::MAP_WORD_BITS-1:0]   avail;
    logic [bba_pkg::MAP_WORD_BITS-1:0]   blk_bit_mask;
    logic [bba_pkg::BIT_IDX_W-1:0]       pos;
    logic [bba_pkg::WORD_IDX_W-1:0]      req_word;
    logic [bba_pkg::WORD_IDX_W-1:0]      in_word;
    logic                                req_out_of_range;
    logic                                in_accept;
    logic                                out_free;
    logic                                done;
    logic                                wr_want;
    bba_pkg::t_resp                      res;

    assign in_accept = i_in_valid && o_in_ready;
    assign out_free  = !r_out_valid || i_out_ready;

    // Bitmap word RAM
    bba_map_ram u_map_ram (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (ram_req),
        .o_rd_data(rd_word)
    );

    // Request decode helpers
    assign in_word  = bba_pkg::WORD_IDX_W'(i_in_data.block_number >> bba_pkg::BIT_IDX_W);
    assign req_word = bba_pkg::WORD_IDX_W'(r_req.block_number >> bba_pkg::BIT_IDX_W);
    assign req_out_of_range = (32'(r_req.block_number) >= bba_pkg::NUM_BLOCKS);
    assign blk_bit_mask = bba_pkg::MAP_WORD_BITS'(1)
                          << r_req.block_number[bba_pkg::BIT_IDX_W-1:0];

    // Blocks eligible for allocation in the current word: skip block 0 and
    // anything past the end of the map
    always_comb begin
        for (int b = 0; b < bba_pkg::MAP_WORD_BITS; b++) begin
            alloc_mask[b] = ((int'(r_word) * bba_pkg::MAP_WORD_BITS + b) != 0) &&
                            ((int'(r_word) * bba_pkg::MAP_WORD_BITS + b) < bba_pkg::NUM_BLOCKS);
        end
    end

    assign avail = ~rd_word & alloc_mask;
    assign pos   = bba_pkg::lowest_set(avail);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bba_pkg::ST_IDLE: begin
                if (in_accept) begin
                    n_state = bba_pkg::ST_LOOK;
                end
            end
            bba_pkg::ST_LOOK: begin
                if (done && out_free) begin
                    n_state = bba_pkg::ST_IDLE;
                end
            end
            default: n_state = bba_pkg::ST_IDLE;
        endcase
    end

    // Datapath and RAM control
    always_comb begin
        ram_req          = '0;
        n_word           = r_word;
        n_free_count     = r_free_count;
        done             = 1'b0;
        wr_want          = 1'b0;
        res              = '0;
        res.status       = bba_pkg::STAT_OK;
        o_in_ready       = 1'b0;

        unique case (r_state)
            bba_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (in_accept) begin
                    ram_req.rd_en   = 1'b1;
                    ram_req.rd_addr = (i_in_data.command == bba_pkg::CMD_ALLOC) ? '0 : in_word;
                    n_word          = ram_req.rd_addr;
                end
            end
            bba_pkg::ST_LOOK: begin
                case (r_req.command)
                    bba_pkg::CMD_ALLOC: begin
                        if (|avail) begin
                            done            = 1'b1;
                            wr_want         = 1'b1;
                            ram_req.wr_addr = r_word;
                            ram_req.wr_data = rd_word | (bba_pkg::MAP_WORD_BITS'(1) << pos);
                            res.block_out   = bba_pkg::BLK_W'({r_word, pos});
                            if (r_free_count != '0) begin
                                n_free_count = r_free_count - 1'b1;
                            end
                        end else if (r_word == bba_pkg::WORD_IDX_W'(bba_pkg::MAP_WORDS - 1)) begin
                            done       = 1'b1;
                            res.status = bba_pkg::STAT_FULL;
                        end else begin
                            // Move on to the next word
                            ram_req.rd_en   = 1'b1;
                            ram_req.rd_addr = r_word + 1'b1;
                            n_word          = ram_req.rd_addr;
                        end
                    end
                    bba_pkg::CMD_FREE: begin
                        done = 1'b1;
                        if (r_req.block_number == '0 || req_out_of_range) begin
                            res.status = bba_pkg::STAT_INVALID;
                        end else if ((rd_word & blk_bit_mask) == '0) begin
                            res.status = bba_pkg::STAT_ALREADY_FREE;
                        end else begin
                            wr_want         = 1'b1;
                            ram_req.wr_addr = req_word;
                            ram_req.wr_data = rd_word & ~blk_bit_mask;
                            if (r_free_count < bba_pkg::COUNT_W'(bba_pkg::NUM_BLOCKS)) begin
                                n_free_count = r_free_count + 1'b1;
                            end
                        end
                    end
                    bba_pkg::CMD_QUERY: begin
                        done = 1'b1;
                        if (req_out_of_range) begin
                            res.status = bba_pkg::STAT_INVALID;
                        end else begin
                            res.is_used = |(rd_word & blk_bit_mask);
                        end
                    end
                    default: begin
                        done       = 1'b1;
                        res.status = bba_pkg::STAT_INVALID;
                    end
                endcase
            end
            default: ;
        endcase

        // Commit the write only when the result can be handed over
        ram_req.wr_en  = wr_want && done && out_free;
        res.free_total = n_free_count;
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= bba_pkg::ST_IDLE;
            r_free_count <= bba_pkg::COUNT_W'(bba_pkg::NUM_BLOCKS);
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == bba_pkg::ST_LOOK && done && out_free) begin
                r_free_count <= n_free_count;
                r_out_valid  <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_req <= i_in_data;
        end
        r_word <= n_word;
        if (r_state == bba_pkg::ST_LOOK && done && out_free) begin
            r_out_data <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

@@ tb/bba_result_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_result_checker
// Watches the request and result channels of the bitmap block allocator,
// keeps its own copy of the used-block bitmap and free count, predicts the
// result of every accepted request and compares each result beat with the
// oldest prediction. Hands back the failure count and the number of results
// still owed.
// ----------------------------------------------------------------------------
module bba_result_checker (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_in_ready,
    input  bba_pkg::t_req  i_in_data,
    input  logic           i_out_valid,
    input  logic           i_out_ready,
    input  bba_pkg::t_resp i_out_data,
    output int             o_fail_count,
    output int             o_outstanding
);

    localparam int REPORT_LIMIT = 10;

    // Shadow allocator state
    bit [bba_pkg::NUM_BLOCKS-1:0] used_blocks;
    logic [bba_pkg::COUNT_W-1:0]  shadow_free;

    // Results owed by the block, oldest first
    bba_pkg::t_resp owed_results[$];
    bba_pkg::t_resp owed;
    int             fail_total;

    assign o_fail_count = fail_total;

    // Applies one request to the shadow state and returns the result it gives
    function automatic bba_pkg::t_resp apply_request(input bba_pkg::t_req req);
        bba_pkg::t_resp res;
        int             blk;
        bit             found;
        res   = '0;
        blk   = int'(req.block_number);
        found = 1'b0;
        case (req.command)
            bba_pkg::CMD_ALLOC: begin
                res.status = bba_pkg::STAT_FULL;
                // first fit from block 1 upward; block 0 means no block
                for (int b = 1; b < bba_pkg::NUM_BLOCKS; b++) begin
                    if (!found && !used_blocks[b]) begin
                        found          = 1'b1;
                        used_blocks[b] = 1'b1;
                        if (shadow_free != '0) begin
                            shadow_free = shadow_free - 1'b1;
                        end
                        res.block_out = bba_pkg::BLK_W'(b);
                        res.status    = bba_pkg::STAT_OK;
                    end
                end
            end
            bba_pkg::CMD_FREE: begin
                if (blk == 0 || blk >= bba_pkg::NUM_BLOCKS) begin
                    res.status = bba_pkg::STAT_INVALID;
                end else if (!used_blocks[blk]) begin
                    res.status = bba_pkg::STAT_ALREADY_FREE;
                end else begin
                    used_blocks[blk] = 1'b0;
                    if (shadow_free < bba_pkg::COUNT_W'(bba_pkg::NUM_BLOCKS)) begin
                        shadow_free = shadow_free + 1'b1;
                    end
                    res.status = bba_pkg::STAT_OK;
                end
            end
            bba_pkg::CMD_QUERY: begin
                if (blk >= bba_pkg::NUM_BLOCKS) begin
                    res.status = bba_pkg::STAT_INVALID;
                end else begin
                    res.is_used = used_blocks[blk];
                    res.status  = bba_pkg::STAT_OK;
                end
            end
            default: begin
                res.status = bba_pkg::STAT_INVALID;
            end
        endcase
        res.free_total = shadow_free;
        return res;
    endfunction

    task automatic note_failure(input string what, input bba_pkg::t_resp exp,
                                input bba_pkg::t_resp act);
        fail_total++;
        if (fail_total <= REPORT_LIMIT) begin
            $display("%0t %s: exp blk %0d used %0b st %0d free %0d,",
                     $time, what, exp.block_out, exp.is_used, exp.status, exp.free_total,
                     " got blk %0d used %0b st %0d free %0d",
                     act.block_out, act.is_used, act.status, act.free_total);
        end
    endtask

    // Result beats are checked before the request beat of the same edge is
    // predicted, so a result can never be matched to its own request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            used_blocks = '0;
            shadow_free = bba_pkg::COUNT_W'(bba_pkg::NUM_BLOCKS);
            owed_results.delete();
            fail_total  = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (owed_results.size() == 0) begin
                    note_failure("result beat with nothing owed", '0, i_out_data);
                end else begin
                    owed = owed_results.pop_front();
                    if (i_out_data.block_out !== owed.block_out ||
                        i_out_data.is_used !== owed.is_used ||
                        i_out_data.status !== owed.status ||
                        i_out_data.free_total !== owed.free_total) begin
                        note_failure("result mismatch", owed, i_out_data);
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                owed_results.push_back(apply_request(i_in_data));
            end
        end
        o_outstanding <= owed_results.size();
    end

endmodule

@@ tb/tb_bitmap_block_allocator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bitmap_block_allocator
// Drives allocate, free and query requests into the bitmap block allocator:
// a short directed run over the corner cases, then three random phases
// (mixed traffic, a fill run that drives the map to full, churn near full)
// under varying idle on both channels. Checking is done by the checker.
// ----------------------------------------------------------------------------
module tb_bitmap_block_allocator;

    // Spare command code, treated as invalid by the block
    localparam logic [bba_pkg::CMD_W-1:0] CMD_RESERVED = 2'd3;
    localparam int                        DRAIN_TAIL   = 40;

    logic           clk       = 1'b0;
    logic           rst_n     = 1'b0;
    logic           in_valid  = 1'b0;
    logic           in_ready;
    bba_pkg::t_req  in_data   = '0;
    logic           out_valid;
    logic           out_ready = 1'b0;
    bba_pkg::t_resp out_data;
    int             fail_count;
    int             outstanding;

    int     tx_idle_pct = 15;
    int     rx_idle_pct = 47;
    int     fill_est    = 0;

    bitmap_block_allocator dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    bba_result_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_in_data     (in_data),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_out_data    (out_data),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    // Clock
    initial begin
        forever #5 clk = ~clk;
    end

    // Result side back-pressure
    always @(posedge clk) begin
        out_ready <= ($urandom_range(99, 0) >= rx_idle_pct);
    end

    // One request beat: random idle first, then hold valid until taken
    task automatic send_request(input logic [bba_pkg::CMD_W-1:0] cmd,
                                input logic [bba_pkg::BLK_W-1:0] blk);
        while (tx_idle_pct != 0 && $urandom_range(99, 0) < tx_idle_pct) begin
            in_valid <= 1'b0;
            in_data  <= {2'($urandom), 10'($urandom)};
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= {cmd, blk};
        do @(posedge clk); while (!in_ready);
    endtask

    // Hold off new requests until every owed result has come back
    task automatic wait_for_drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    // Free and query targets lean towards the low, mostly allocated region
    function automatic logic [bba_pkg::BLK_W-1:0] pick_block();
        int span;
        span = (fill_est < 1000) ? fill_est + 16 : 1023;
        if ($urandom_range(99, 0) < 70) begin
            return bba_pkg::BLK_W'($urandom_range(span, 0));
        end
        return bba_pkg::BLK_W'($urandom_range(1023, 0));
    endfunction

    task automatic run_random_phase(input int beats, input int tx_pct, input int rx_pct,
                                    input int alloc_pct, input int free_pct,
                                    input int query_pct);
        int roll;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        for (int n = 0; n < beats; n++) begin
            if ($urandom_range(63, 0) == 0) begin
                wait_for_drain();
            end
            roll = $urandom_range(99, 0);
            if (roll < alloc_pct) begin
                if (fill_est < 1023) fill_est++;
                send_request(bba_pkg::CMD_ALLOC, bba_pkg::BLK_W'($urandom));
            end else if (roll < alloc_pct + free_pct) begin
                if (fill_est > 0) fill_est--;
                send_request(bba_pkg::CMD_FREE, pick_block());
            end else if (roll < alloc_pct + free_pct + query_pct) begin
                send_request(bba_pkg::CMD_QUERY, pick_block());
            end else begin
                send_request(CMD_RESERVED, bba_pkg::BLK_W'($urandom));
            end
        end
        wait_for_drain();
    endtask

    // Stimulus and verdict
    initial begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed corner cases on an empty map
        send_request(bba_pkg::CMD_QUERY, 10'd0);
        send_request(bba_pkg::CMD_QUERY, 10'd1023);
        send_request(bba_pkg::CMD_FREE, 10'd0);
        send_request(bba_pkg::CMD_FREE, 10'd5);
        send_request(bba_pkg::CMD_FREE, 10'd1023);
        send_request(CMD_RESERVED, 10'h3FF);
        send_request(bba_pkg::CMD_ALLOC, 10'h3FF);
        send_request(bba_pkg::CMD_ALLOC, 10'd0);
        send_request(bba_pkg::CMD_ALLOC, 10'h155);
        send_request(bba_pkg::CMD_QUERY, 10'd2);
        send_request(bba_pkg::CMD_QUERY, 10'd0);
        send_request(bba_pkg::CMD_FREE, 10'd2);
        send_request(bba_pkg::CMD_FREE, 10'd2);
        send_request(bba_pkg::CMD_QUERY, 10'd2);
        send_request(bba_pkg::CMD_ALLOC, 10'h2AA);
        send_request(bba_pkg::CMD_ALLOC, 10'd0);
        send_request(bba_pkg::CMD_QUERY, 10'd4);
        send_request(bba_pkg::CMD_QUERY, 10'h200);
        send_request(bba_pkg::CMD_FREE, 10'h155);
        send_request(bba_pkg::CMD_QUERY, 10'h2AA);
        send_request(CMD_RESERVED, 10'd0);
        send_request(bba_pkg::CMD_FREE, 10'd1);
        send_request(bba_pkg::CMD_ALLOC, 10'd0);
        fill_est = 4;
        wait_for_drain();

        // mixed traffic, then a fill run past full, then churn near full
        run_random_phase(300, 15, 47, 50, 25, 20);
        run_random_phase(1000, 47, 15, 97, 1, 1);
        run_random_phase(300, 0, 0, 40, 35, 20);

        repeat (DRAIN_TAIL) @(posedge clk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("tb_bitmap_block_allocator: PASS");
        end else begin
            $display("tb_bitmap_block_allocator: FAIL");
        end
        $finish;
    end

    // Run limit
    initial begin
        #10_000_000;
        $display("tb_bitmap_block_allocator: FAIL");
        $finish;
    end

endmodule
